### src/mvwo_pkg.sv
package mvwo_pkg;

   // default sizing handed to the top level
   localparam int VOICES_DEFAULT     = 16;
   localparam int SINE_DEPTH_DEFAULT = 256;
   localparam int PHASE_BITS_DEFAULT = 32;

   // fixed field widths
   localparam int VOICE_W     = 4;
   localparam int STEP_W      = 32;
   localparam int AMP_W       = 16;
   localparam int OCT_W       = 3;
   localparam int SHAPE_W     = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   // command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OCTAVE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHAPE  = 8'd1;

   // octave codes
   localparam logic [OCT_W-1:0] OCT_QUARTER = 3'd0;
   localparam logic [OCT_W-1:0] OCT_HALF    = 3'd1;
   localparam logic [OCT_W-1:0] OCT_UNITY   = 3'd2;
   localparam logic [OCT_W-1:0] OCT_DOUBLE  = 3'd3;
   localparam logic [OCT_W-1:0] OCT_QUAD    = 3'd4;

   // wave shape codes
   localparam logic [SHAPE_W-1:0] SHAPE_SAW      = 2'd0;
   localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd1;
   localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd2;
   localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd3;

   // Q30 angles used to build the sine table
   localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
   localparam logic [63:0] Q30_PI      = 64'd3373259426;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

   // taylor series divisors (2k)(2k+1) for k = 1..7
   localparam int TAYLOR_TERMS = 7;
   localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
   };

   // result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [VOICE_W-1:0]      voice_out;
      logic signed [AMP_W-1:0] amplitude;
   } rsp_item_type;

   typedef struct packed {
      logic [QCOUNT_W-1:0] count;
   } queue_status_type;

endpackage

### src/mvwo_req_if.sv
interface mvwo_req_if;
   import mvwo_pkg::*;

   logic               valid;
   logic               ready;
   logic               cmd;
   logic [VOICE_W-1:0] voice;
   logic [STEP_W-1:0]  phase_step;

   modport source (output valid, cmd, voice, phase_step, input ready);
   modport sink   (input valid, cmd, voice, phase_step, output ready);
endinterface

### src/mvwo_rsp_if.sv
interface mvwo_rsp_if;
   import mvwo_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [VOICE_W-1:0]      voice_out;
   logic signed [AMP_W-1:0] amplitude;

   modport source (output valid, voice_out, amplitude, input ready);
   modport sink   (input valid, voice_out, amplitude, output ready);
endinterface

### src/mvwo_csr_if.sv
interface mvwo_csr_if;
   import mvwo_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/mvwo_out_queue.sv
module mvwo_out_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mvwo_pkg::rsp_item_type     push_item,
   output mvwo_pkg::queue_status_type status,
   mvwo_rsp_if.source                 rsp
);
   import mvwo_pkg::*;

   rsp_item_type        slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   logic                pop;

   assign pop = rsp.valid && rsp.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCOUNT_W'(push) - QCOUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp.valid     = (count_ff != '0);
   assign rsp.voice_out = slots_ff[rd_ptr_ff].voice_out;
   assign rsp.amplitude = slots_ff[rd_ptr_ff].amplitude;
   assign status.count  = count_ff;
endmodule

### src/multi_voice_wave_oscillator.sv
// Multi-voice wave oscillator.
// req channel: one item per sample slot. cmd sample reads the named voice's
// phase, returns its amplitude (saw, square, triangle or sine table) and adds
// the octave-scaled phase_step to it. cmd clear zeroes every voice phase and
// returns amplitude 0. Voice numbers wrap modulo VOICES.
// rsp channel: exactly one item per req item, in order, voice_out and Q1.15
// amplitude.
// csr channel: index 0 octave_shift, index 1 wave_shape; always ready, write
// only while no items are in flight.
// Throughput is one item per cycle while req.ready is high, set by the
// read-modify-write of the single phase memory: one read and one write port,
// with the write of the previous item forwarded when it hits the same voice.
// An accepted item passes the stage 1 and stage 2 registers into the queue.
// Reset clears pipeline and queue, sets octave to unchanged and shape to saw;
// per-voice live flags make every phase read as zero, no clearing pass.
// When rsp stalls, a 4-item result queue keeps taking items; req.ready drops
// once queued plus in-flight items reach 4.
module multi_voice_wave_oscillator #(
   parameter int VOICES     = mvwo_pkg::VOICES_DEFAULT,
   parameter int SINE_DEPTH = mvwo_pkg::SINE_DEPTH_DEFAULT,
   parameter int PHASE_BITS = mvwo_pkg::PHASE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mvwo_req_if.sink   req,
   mvwo_rsp_if.source rsp,
   mvwo_csr_if.sink   csr
);
   import mvwo_pkg::*;

   localparam int SLOT_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int IDX_W   = $clog2(SINE_DEPTH);
   localparam int SD_W    = $clog2(SINE_DEPTH) + 1;
   localparam int PROD_W  = PHASE_BITS + SD_W;
   localparam int SLOT_N  = 1 << VOICE_W;

   typedef logic [AMP_W-1:0]   sine_table_type [SINE_DEPTH];
   typedef logic [VOICE_W-1:0] slot_table_type [SLOT_N];

   function automatic sine_table_type build_sine();
      sine_table_type tbl;
      logic [63:0]    ang;
      logic [63:0]    mag;
      logic [63:0]    sum;
      logic [63:0]    term;
      logic           neg;
      for (int i = 0; i < SINE_DEPTH; i++) begin
         ang = (64'(i) * Q30_TWO_PI) / SINE_DEPTH;
         neg = 1'b0;
         if (ang >= Q30_PI) begin
            neg = 1'b1;
            ang = ang - Q30_PI;
         end
         if (ang > Q30_HALF_PI) begin
            ang = (ang < Q30_PI) ? Q30_PI - ang : 64'd0;
         end
         sum  = ang;
         term = ang;
         for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = (term * ang) >> 30;
            term = (term * ang) >> 30;
            term = term / TAYLOR_DIV[k-1];
            if ((k & 1) != 0) begin
               sum = (sum > term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         mag = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
         if (mag > 64'd32767) begin
            mag = 64'd32767;
         end
         tbl[i] = neg ? 16'(64'h10000 - mag) : 16'(mag);
      end
      return tbl;
   endfunction

   function automatic slot_table_type build_slots();
      slot_table_type tbl;
      for (int i = 0; i < SLOT_N; i++) begin
         tbl[i] = VOICE_W'(i % VOICES);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine();
   localparam slot_table_type SLOT_TABLE = build_slots();

   // configuration
   logic [OCT_W-1:0]   octave_ff;
   logic [SHAPE_W-1:0] shape_ff;

   // phase memory and its live flags
   logic [PHASE_BITS-1:0] phase_mem [VOICES];
   logic [PHASE_BITS-1:0] rd_ff;
   logic [VOICES-1:0]     live_ff, live_in;

   // write forwarding from the previous item
   logic                  fwd_v_ff;
   logic [SLOT_W-1:0]     fwd_addr_ff;
   logic [PHASE_BITS-1:0] fwd_data_ff;

   // stage 1
   logic                  v1_ff, v1_in;
   logic                  cmd1_ff;
   logic [VOICE_W-1:0]    slot1_ff;
   logic [PHASE_BITS-1:0] step1_ff;

   // stage 2
   logic                    v2_ff;
   logic [VOICE_W-1:0]      slot2_ff;
   logic signed [AMP_W-1:0] amp2_ff, amp2_in;
   logic                    sine2_ff, sine2_in;
   logic [AMP_W-1:0]        rom_ff;

   logic                  accept;
   logic [VOICE_W-1:0]    slot0;
   logic [SLOT_W-1:0]     addr0;
   logic [PHASE_BITS-1:0] step_base;
   logic [PHASE_BITS-1:0] step0;

   logic [SLOT_W-1:0]       addr1;
   logic [PHASE_BITS-1:0]   phase_cur;
   logic [PHASE_BITS-1:0]   phase_new;
   logic                    wr_en;
   logic                    clear;
   logic [AMP_W-1:0]        p16;
   logic signed [18:0]      two_p;
   logic signed [18:0]      tri_wide;
   logic signed [AMP_W-1:0] tri_amp;
   logic [PROD_W-1:0]       sine_prod;
   logic [IDX_W-1:0]        sine_idx;

   logic [QCOUNT_W:0] in_flight;
   queue_status_type  q_status;
   rsp_item_type      push_item;

   // configuration port
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_ff <= OCT_UNITY;
         shape_ff  <= SHAPE_SAW;
      end else if (csr.valid && csr.ready) begin
         if (csr.index == CSR_OCTAVE) begin
            octave_ff <= csr.data[OCT_W-1:0];
         end
         if (csr.index == CSR_SHAPE) begin
            shape_ff <= csr.data[SHAPE_W-1:0];
         end
      end
   end

   // stage 0: accept, voice slot, step scaling, phase read
   assign in_flight = (QCOUNT_W+1)'(q_status.count) + (QCOUNT_W+1)'(v1_ff)
                    + (QCOUNT_W+1)'(v2_ff);
   assign req.ready = (in_flight < (QCOUNT_W+1)'(QUEUE_DEPTH));
   assign accept    = req.valid && req.ready;
   assign slot0     = SLOT_TABLE[req.voice];
   assign addr0     = SLOT_W'(slot0);
   assign step_base = req.phase_step[STEP_W-1 -: PHASE_BITS];

   always_comb begin
      case (octave_ff)
         OCT_QUARTER: step0 = step_base >> 2;
         OCT_HALF:    step0 = step_base >> 1;
         OCT_DOUBLE:  step0 = step_base << 1;
         OCT_QUAD:    step0 = step_base << 2;
         default:     step0 = step_base;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= phase_mem[addr0];
      if (wr_en) begin
         phase_mem[addr1] <= phase_new;
      end
   end

   assign v1_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd1_ff  <= req.cmd;
      slot1_ff <= slot0;
      step1_ff <= step0;
   end

   // stage 1: phase select, write-back, waveform
   assign addr1 = SLOT_W'(slot1_ff);
   assign wr_en = v1_ff && (cmd1_ff == CMD_SAMPLE);
   assign clear = v1_ff && (cmd1_ff == CMD_CLEAR);

   always_comb begin
      if (fwd_v_ff && (fwd_addr_ff == addr1)) begin
         phase_cur = fwd_data_ff;
      end else if (live_ff[addr1]) begin
         phase_cur = rd_ff;
      end else begin
         phase_cur = '0;
      end
   end

   assign phase_new = phase_cur + step1_ff;

   always_comb begin
      live_in = live_ff;
      if (clear) begin
         live_in = '0;
      end else if (wr_en) begin
         live_in[addr1] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         fwd_v_ff <= 1'b0;
      end else begin
         live_ff  <= live_in;
         fwd_v_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= addr1;
      fwd_data_ff <= phase_new;
   end

   assign p16   = phase_cur[PHASE_BITS-1 -: AMP_W];
   assign two_p = $signed({2'b00, p16, 1'b0});

   always_comb begin
      if (p16[AMP_W-1]) begin
         tri_wide = 19'sd98304 - two_p;
      end else begin
         tri_wide = two_p - 19'sd32768;
      end
      // only the top of the falling edge overshoots
      if (tri_wide > 19'sd32767) begin
         tri_amp = 16'sh7fff;
      end else begin
         tri_amp = AMP_W'(tri_wide);
      end
   end

   assign sine_prod = PROD_W'(phase_cur) * PROD_W'(SINE_DEPTH);
   assign sine_idx  = sine_prod[PHASE_BITS +: IDX_W];

   always_comb begin
      sine2_in = 1'b0;
      if (clear) begin
         amp2_in = '0;
      end else begin
         case (shape_ff)
            SHAPE_SAW:      amp2_in = $signed({~p16[AMP_W-1], p16[AMP_W-2:0]});
            SHAPE_SQUARE:   amp2_in = p16[AMP_W-1] ? 16'sh8000 : 16'sh7fff;
            SHAPE_TRIANGLE: amp2_in = tri_amp;
            default: begin
               amp2_in  = '0;
               sine2_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot2_ff <= slot1_ff;
      amp2_ff  <= amp2_in;
      sine2_ff <= sine2_in;
      rom_ff   <= SINE_TABLE[sine_idx];
   end

   // stage 2: result into the queue
   assign push_item.voice_out = slot2_ff;
   assign push_item.amplitude = sine2_ff ? $signed(rom_ff) : amp2_ff;

   mvwo_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (v2_ff),
      .push_item (push_item),
      .status    (q_status),
      .rsp       (rsp)
   );

   // queue never takes more than it can hold
   assert property (@(posedge clock) disable iff (reset)
      in_flight <= (QCOUNT_W+1)'(QUEUE_DEPTH))
      else $error("result queue overcommitted");

   // back-to-back samples on one voice see the phase just written
   assert property (@(posedge clock) disable iff (reset)
      (wr_en ##1 (wr_en && (addr1 == $past(addr1)))) |-> (phase_cur == $past(phase_new)))
      else $error("phase forwarding lost an update");

   // a sample right after a clear starts from phase zero
   assert property (@(posedge clock) disable iff (reset)
      (clear ##1 wr_en) |-> (phase_cur == '0))
      else $error("phase not zero after clear");

   // every accepted item passes v1_ff and then v2_ff on its way to the queue
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 v2_ff)
      else $error("item dropped in pipeline");
endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import mvwo_pkg::*;

   localparam int VOICES      = VOICES_DEFAULT;
   localparam int SINE_DEPTH  = SINE_DEPTH_DEFAULT;
   localparam int PHASE_BITS  = PHASE_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 100;

   // octave code outside the defined range, block treats it as unchanged
   localparam logic [OCT_W-1:0] OCT_OUT_OF_RANGE = 3'd7;
   // register index that decodes to nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 8'd2;
   localparam logic [VOICE_W-1:0] VOICE_TOP = '1;

   class oscillator_mirror;
      logic [PHASE_BITS-1:0] phase_acc [VOICES];
      logic signed [AMP_W-1:0] sine_table [SINE_DEPTH];
      logic [OCT_W-1:0] octave;
      logic [SHAPE_W-1:0] shape;
      rsp_item_type samples_due [$];
      int mismatch_count;

      function new();
         foreach (phase_acc[i]) phase_acc[i] = '0;
         octave = OCT_UNITY;
         shape = SHAPE_SAW;
         mismatch_count = 0;
         fill_sine_table();
      endfunction

      // sine of a Q30 angle in [0, pi/2], alternating series up to x^15
      function automatic longint unsigned quarter_sine(longint unsigned x);
         longint unsigned sum;
         longint unsigned term;
         int k;
         sum = x;
         term = x;
         for (k = 1; k <= TAYLOR_TERMS; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[k-1];
            if (k % 2 == 1) begin
               sum = (sum > term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         return sum;
      endfunction

      function void fill_sine_table();
         longint unsigned angle;
         longint unsigned mag;
         bit neg;
         int i;
         for (i = 0; i < SINE_DEPTH; i++) begin
            angle = (64'(i) * Q30_TWO_PI) / 64'(SINE_DEPTH);
            neg = 1'b0;
            if (angle >= Q30_PI) begin
               neg = 1'b1;
               angle = angle - Q30_PI;
            end
            if (angle > Q30_HALF_PI) begin
               angle = (angle < Q30_PI) ? Q30_PI - angle : 64'd0;
            end
            mag = (quarter_sine(angle) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (mag > 64'd32767) begin
               mag = 64'd32767;
            end
            sine_table[i] = neg ? 16'(64'h10000 - mag) : 16'(mag);
         end
      endfunction

      function automatic logic signed [AMP_W-1:0] wave_sample(logic [PHASE_BITS-1:0] ph);
         int top;
         int level;
         longint unsigned idx;
         top = int'(ph[PHASE_BITS-1 -: 16]);
         case (shape)
            SHAPE_SAW: level = top - 32768;
            SHAPE_SQUARE: level = (top < 32768) ? 32767 : -32768;
            SHAPE_TRIANGLE: begin
               level = (top < 32768) ? 2 * top - 32768 : 98304 - 2 * top;
               if (level > 32767) begin
                  level = 32767;
               end
            end
            default: begin
               idx = (64'(ph) * 64'(SINE_DEPTH)) >> PHASE_BITS;
               level = int'(sine_table[idx]);
            end
         endcase
         return 16'(level);
      endfunction

      function automatic logic [PHASE_BITS-1:0] octave_step(logic [STEP_W-1:0] step);
         logic [PHASE_BITS-1:0] s;
         s = step[STEP_W-1 -: PHASE_BITS];
         case (octave)
            OCT_QUARTER: s = s >> 2;
            OCT_HALF:    s = s >> 1;
            OCT_DOUBLE:  s = s << 1;
            OCT_QUAD:    s = s << 2;
            default:     s = s;
         endcase
         return s;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_OCTAVE) begin
            octave = data[OCT_W-1:0];
         end else if (index == CSR_SHAPE) begin
            shape = data[SHAPE_W-1:0];
         end
      endfunction

      function void take_request(logic cmd, logic [VOICE_W-1:0] voice,
                                 logic [STEP_W-1:0] step);
         rsp_item_type due;
         int slot;
         slot = int'(voice) % VOICES;
         due.voice_out = VOICE_W'(slot);
         if (cmd == CMD_CLEAR) begin
            foreach (phase_acc[i]) phase_acc[i] = '0;
            due.amplitude = '0;
         end else begin
            due.amplitude = wave_sample(phase_acc[slot]);
            phase_acc[slot] = phase_acc[slot] + octave_step(step);
         end
         samples_due.push_back(due);
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t mismatch: %s", $time, msg);
         end
      endtask

      task check_amplitude(logic [VOICE_W-1:0] voice_out, logic signed [AMP_W-1:0] amplitude);
         rsp_item_type due;
         if (samples_due.size() == 0) begin
            report_mismatch($sformatf("result voice %0d amp %0d with nothing due",
                                      voice_out, amplitude));
            return;
         end
         due = samples_due.pop_front();
         if (voice_out !== due.voice_out) begin
            report_mismatch($sformatf("voice_out %0d, wanted %0d", voice_out, due.voice_out));
         end
         if (amplitude !== due.amplitude) begin
            report_mismatch($sformatf("voice %0d amplitude %0d, wanted %0d",
                                      due.voice_out, amplitude, due.amplitude));
         end
      endtask

      function int pending();
         return samples_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int cycle_count = 0;
   int stall_left = 0;
   bit req_idle_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   logic [VOICE_W-1:0] last_voice = '0;
   oscillator_mirror mirror;

   logic [OCT_W-1:0] dir_octave [5] = '{OCT_QUARTER, OCT_QUAD, OCT_OUT_OF_RANGE,
                                        OCT_HALF, OCT_DOUBLE};
   logic [SHAPE_W-1:0] dir_shape [5] = '{SHAPE_SAW, SHAPE_SQUARE, SHAPE_TRIANGLE,
                                         SHAPE_SINE, SHAPE_TRIANGLE};

   mvwo_req_if req_ch ();
   mvwo_rsp_if rsp_ch ();
   mvwo_csr_if csr_ch ();

   multi_voice_wave_oscillator i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            mirror.take_request(req_ch.cmd, req_ch.voice, req_ch.phase_step);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            mirror.check_amplitude(rsp_ch.voice_out, rsp_ch.amplitude);
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      int r;
      if (reset || !rsp_stalls_on) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         r = $urandom_range(0, 99);
         if (r < 75) begin
            stall_left = 0;
         end else if (r < 93) begin
            stall_left = $urandom_range(1, 3);
         end else begin
            stall_left = $urandom_range(10, 40);
         end
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!req_idle_on || r < 70) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [STEP_W-1:0] pick_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return $urandom();
      end else if (r < 65) begin
         return $urandom_range(0, 32'h000F_FFFF);
      end else if (r < 85) begin
         return 32'h1 << $urandom_range(0, 31);
      end
      case ($urandom_range(0, 3))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   // valid stays high across back-to-back items; only a gap lowers it
   task automatic send_item(input logic cmd, input logic [VOICE_W-1:0] voice,
                            input logic [STEP_W-1:0] step);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.voice <= voice;
      req_ch.phase_step <= step;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      mirror.set_register(index, data);
   endtask

   // noisy writes put junk in the unused data bits and hit an unused index
   task automatic configure(input logic [OCT_W-1:0] oct, input logic [SHAPE_W-1:0] shp,
                            input bit noisy);
      if (noisy) begin
         write_register(CSR_OCTAVE, {29'($urandom()), oct});
         write_register(CSR_SHAPE, {30'($urandom()), shp});
         write_register(CSR_UNUSED, $urandom());
      end else begin
         write_register(CSR_OCTAVE, CSR_DATA_W'(oct));
         write_register(CSR_SHAPE, CSR_DATA_W'(shp));
      end
      csr_ch.valid <= 1'b0;
   endtask

   // drop valid and let the monitor note the last accepted item before waiting
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int g;
      int ph;
      int n;
      logic cmd;
      logic [VOICE_W-1:0] voice;

      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_SAMPLE;
      req_ch.voice <= '0;
      req_ch.phase_step <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_OCTAVE;
      csr_ch.data <= '0;
      mirror = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // each group ends with a clear so the next starts from zero phase
      for (g = 0; g < 5; g++) begin
         configure(dir_octave[g], dir_shape[g], 1'b0);
         send_item(CMD_SAMPLE, '0, 32'h8000_0000);
         send_item(CMD_SAMPLE, '0, 32'h4000_0000);
         send_item(CMD_SAMPLE, VOICE_TOP, 32'hFFFF_FFFF);
         send_item(CMD_SAMPLE, VOICE_TOP, 32'h0000_0000);
         send_item(CMD_CLEAR, 4'h9, 32'h1234_5678);
         drain();
      end

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0) begin
            configure(OCT_UNITY, SHAPE_SINE, 1'b1);
         end else if (ph == 1) begin
            configure(OCT_QUAD, SHAPE_SAW, 1'b0);
         end else if (ph == 2) begin
            configure(OCT_QUARTER, SHAPE_TRIANGLE, 1'b0);
         end else begin
            configure(OCT_W'($urandom_range(0, 7)), SHAPE_W'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
         end
         req_idle_on = (ph % 4 != 1);
         rsp_stalls_on = (ph % 4 != 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            cmd = ($urandom_range(0, 99) < 4) ? CMD_CLEAR : CMD_SAMPLE;
            // repeats of one voice exercise the back-to-back update path
            voice = ($urandom_range(0, 99) < 30) ? last_voice : VOICE_W'($urandom());
            last_voice = voice;
            send_item(cmd, voice, pick_step());
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (mirror.mismatch_count == 0 && mirror.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
